// ===== design/tlg5_pkg.sv =====
// ----------------------------------------------------------------------------
// tlg5_pkg: shared types and constants for pixel reconstruction
// Payload structs, register indexes and position flags used across the block.
// ----------------------------------------------------------------------------
package tlg5_pkg;

   // configuration register indexes
   localparam logic [1:0] CSR_HAS_ALPHA    = 2'd0;
   localparam logic [1:0] CSR_LINE_WIDTH   = 2'd1;
   localparam logic [1:0] CSR_FRAME_HEIGHT = 2'd2;

   localparam int CSR_DATA_W = 16;

   // reset values of the configuration registers
   localparam logic        HAS_ALPHA_RST    = 1'b1;
   localparam logic [12:0] LINE_WIDTH_RST   = 13'd4096;
   localparam logic [15:0] FRAME_HEIGHT_RST = 16'd1;

   // alpha value in three-channel mode
   localparam logic [7:0] OPAQUE = 8'hFF;

   localparam int NUM_LANES = 4;

   typedef struct packed {
      logic [7:0] alpha_delta;
      logic [7:0] red_delta;
      logic [7:0] green_delta;
      logic [7:0] blue_delta;
   } req_type;

   typedef struct packed {
      logic       frame_end;
      logic       row_end;
      logic [7:0] alpha_out;
      logic [7:0] red_out;
      logic [7:0] green_out;
      logic [7:0] blue_out;
   } rsp_type;

   // position of the pixel being accepted
   typedef struct packed {
      logic row_first;
      logic col_first;
      logic row_last;
      logic frame_last;
   } pos_flags_type;

endpackage

// ===== design/tlg5_ram.sv =====
// ----------------------------------------------------------------------------
// tlg5_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read returns old data on a
// same-address collision.
// ----------------------------------------------------------------------------
module tlg5_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/tlg5_pos.sv =====
// ----------------------------------------------------------------------------
// tlg5_pos: raster position counters
// Tracks column and row of the next pixel and flags row and frame ends.
// ----------------------------------------------------------------------------
module tlg5_pos #(
   parameter int MAX_WIDTH = 4096,
   parameter int CW        = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  logic [12:0]            line_width,
   input  logic [15:0]            frame_height,
   output logic [CW-1:0]          col,
   output tlg5_pkg::pos_flags_type flags
);

   localparam logic [16:0] MAX_W = 17'(MAX_WIDTH);

   logic [CW-1:0] col_ff, col_in;
   logic [15:0]   row_ff, row_in;
   logic [16:0]   width_eff;
   logic [16:0]   last_col;
   logic [15:0]   last_row;
   logic          row_last;
   logic          frame_last;

   // effective width: zero counts as one, saturate to buffer depth
   always_comb begin
      width_eff = (line_width == 13'd0) ? 17'd1 : {4'd0, line_width};
      if (width_eff > MAX_W) begin
         width_eff = MAX_W;
      end
      last_col = width_eff - 17'd1;
      last_row = (frame_height == 16'd0) ? 16'd0 : frame_height - 16'd1;
   end

   assign row_last   = 17'(col_ff) >= last_col;
   assign frame_last = row_last && (row_ff >= last_row);

   // counter update on each transfer
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (step) begin
         if (row_last) begin
            col_in = '0;
            row_in = frame_last ? 16'd0 : row_ff + 16'd1;
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   assign col              = col_ff;
   assign flags.row_first  = (row_ff == 16'd0);
   assign flags.col_first  = (col_ff == '0);
   assign flags.row_last   = row_last;
   assign flags.frame_last = frame_last;

endmodule

// ===== design/tlg5_lane.sv =====
// ----------------------------------------------------------------------------
// tlg5_lane: one channel of the reconstruction datapath
// Running row sum plus the pixel above, modulo 256; opaque when inactive.
// ----------------------------------------------------------------------------
module tlg5_lane (
   input  logic [7:0] px,
   input  logic [7:0] sum_prev,
   input  logic       clear,
   input  logic [7:0] above,
   input  logic       active,
   output logic [7:0] sum_next,
   output logic [7:0] value
);

   logic [7:0] sum_base;

   assign sum_base = clear ? 8'd0 : sum_prev;
   assign sum_next = active ? sum_base + px : sum_base;
   assign value    = active ? sum_next + above : tlg5_pkg::OPAQUE;

endmodule

// ===== design/tlg5_pixel_reconstruct.sv =====
// ----------------------------------------------------------------------------
// tlg5_pixel_reconstruct: TLG5-style pixel reconstruction stage
// Undoes color decorrelation, adds the running row sum and the line above.
// ----------------------------------------------------------------------------
// Throughput: one pixel per cycle unless the output stalls; the line buffer
// read is issued at accept and the row-sum loop closes through a single byte
// add per lane. Pixels pass the stage 1 register, then the output register.
// Reset: counters, row sums and valids clear; registers return to defaults.
// The line buffer has no reset; the user must only read it once written; the block does not enforce it.
module tlg5_pixel_reconstruct #(
   parameter int MAX_WIDTH = 4096
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  tlg5_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output tlg5_pkg::rsp_type                   rsp_data,
   input  logic                                csr_wr_en,
   input  logic [1:0]                          csr_index,
   input  logic [tlg5_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int NL = tlg5_pkg::NUM_LANES;

   // configuration registers
   logic        has_alpha_ff;
   logic [12:0] line_width_ff;
   logic [15:0] frame_height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         has_alpha_ff    <= tlg5_pkg::HAS_ALPHA_RST;
         line_width_ff   <= tlg5_pkg::LINE_WIDTH_RST;
         frame_height_ff <= tlg5_pkg::FRAME_HEIGHT_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            tlg5_pkg::CSR_HAS_ALPHA:    has_alpha_ff    <= csr_wdata[0];
            tlg5_pkg::CSR_LINE_WIDTH:   line_width_ff   <= csr_wdata[12:0];
            tlg5_pkg::CSR_FRAME_HEIGHT: frame_height_ff <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // handshake control
   logic req_fire;
   logic move;
   logic s1_valid_ff;
   logic rsp_valid_ff;

   assign move      = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || move;
   assign req_fire  = req_valid && req_ready;

   // position counters
   logic [CW-1:0]           pos_col;
   tlg5_pkg::pos_flags_type pos_flags;

   tlg5_pos #(
      .MAX_WIDTH (MAX_WIDTH),
      .CW        (CW)
   ) u_pos (
      .clock        (clock),
      .reset        (reset),
      .step         (req_fire),
      .line_width   (line_width_ff),
      .frame_height (frame_height_ff),
      .col          (pos_col),
      .flags        (pos_flags)
   );

   // stage 1: accepted pixel waiting for the line buffer read
   tlg5_pkg::req_type       s1_req_ff;
   tlg5_pkg::pos_flags_type s1_flags_ff;
   logic [CW-1:0]           s1_col_ff;
   logic                    fwd_ff;
   logic [31:0]             fwd_data_ff;
   logic [31:0]             stored;
   logic [31:0]             ram_rdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_req_ff   <= req_data;
         s1_flags_ff <= pos_flags;
         s1_col_ff   <= pos_col;
         // a read of the entry being written this cycle takes the new value
         fwd_ff      <= move && (s1_col_ff == pos_col);
         fwd_data_ff <= stored;
      end
   end

   tlg5_ram #(
      .WIDTH (32),
      .DEPTH (MAX_WIDTH),
      .AW    (CW)
   ) u_line (
      .clock   (clock),
      .wr_en   (move),
      .wr_addr (s1_col_ff),
      .wr_data (stored),
      .rd_en   (req_fire),
      .rd_addr (pos_col),
      .rd_data (ram_rdata)
   );

   // lanes: decorrelation, running sum and pixel above
   logic [31:0]     above;
   logic [7:0]      px     [NL];
   logic [7:0]      sum_ff [NL];
   logic [7:0]      sum_in [NL];
   logic [7:0]      value  [NL];
   logic [NL-1:0]   lane_active;

   assign above = s1_flags_ff.row_first ? 32'd0 : (fwd_ff ? fwd_data_ff : ram_rdata);

   assign px[0] = s1_req_ff.blue_delta + s1_req_ff.green_delta;
   assign px[1] = s1_req_ff.green_delta;
   assign px[2] = s1_req_ff.red_delta + s1_req_ff.green_delta;
   assign px[3] = s1_req_ff.alpha_delta;

   assign lane_active = {has_alpha_ff, 3'b111};

   for (genvar i = 0; i < NL; i++) begin : g_lane
      tlg5_lane u_lane (
         .px       (px[i]),
         .sum_prev (sum_ff[i]),
         .clear    (s1_flags_ff.col_first),
         .above    (above[8*i +: 8]),
         .active   (lane_active[i]),
         .sum_next (sum_in[i]),
         .value    (value[i])
      );

      always_ff @(posedge clock) begin
         if (reset) begin
            sum_ff[i] <= 8'd0;
         end else if (move) begin
            sum_ff[i] <= sum_in[i];
         end
      end

      assign stored[8*i +: 8] = value[i];
   end

   // merge: output register
   tlg5_pkg::rsp_type rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (move) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (move) begin
         rsp_data_ff.blue_out  <= value[0];
         rsp_data_ff.green_out <= value[1];
         rsp_data_ff.red_out   <= value[2];
         rsp_data_ff.alpha_out <= value[3];
         rsp_data_ff.row_end   <= s1_flags_ff.row_last;
         rsp_data_ff.frame_end <= s1_flags_ff.frame_last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   // no new transfer while stage 1 holds a stalled pixel
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !move) |-> !req_fire)
      else $error("request taken while stage 1 stalled");

   // an accepted pixel occupies stage 1 next cycle
   a_s1_fill: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> s1_valid_ff)
      else $error("accepted pixel lost");

   // a pixel leaving stage 1 shows up as a response
   a_rsp_fill: assert property (@(posedge clock) disable iff (reset)
      move |=> rsp_valid_ff)
      else $error("response missing after stage 1 advance");

   // frame end only on a row end
   a_frame_row: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.frame_end) |-> rsp_data_ff.row_end)
      else $error("frame end without row end");
`endif

endmodule

// ===== bench/tlg5_pixel_reconstruct_tb.sv =====
// ----------------------------------------------------------------------------
// tlg5_pixel_reconstruct_tb: self-checking bench for pixel reconstruction
// Sends raster pixels through the request channel under several register settings.
// Each response is checked against the plan's value, if it has one, or a predictor
// that keeps its own line store, row sums and counters. Covers mid-frame register
// changes, degenerate and saturating sizes, three-channel mode and back-pressure.
// ----------------------------------------------------------------------------
module tlg5_pixel_reconstruct_tb;

   localparam int MAX_W       = 4096;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int PLAN_LEN    = 26;
   localparam int HOLD_CYCLES = 400;

   // one row of the directed plan: either a register write or a pixel
   typedef struct packed {
      logic                            is_csr;
      logic [1:0]                      csr_sel;
      logic [tlg5_pkg::CSR_DATA_W-1:0] csr_val;
      tlg5_pkg::req_type               px;
      logic                            known;
      tlg5_pkg::rsp_type               want;
   } plan_row_type;

   logic                            clock;
   logic                            reset;
   logic                            req_valid;
   logic                            req_ready;
   tlg5_pkg::req_type               req_data;
   logic                            rsp_valid;
   logic                            rsp_ready;
   tlg5_pkg::rsp_type               rsp_data;
   logic                            csr_wr_en;
   logic [1:0]                      csr_index;
   logic [tlg5_pkg::CSR_DATA_W-1:0] csr_wdata;

   // predictor state
   logic [3:0][7:0] line_mem [MAX_W];
   logic [3:0][7:0] row_sum;
   int unsigned     pixel_col;
   logic [15:0]     pixel_row;
   int unsigned     filled_len;
   logic            cfg_alpha;
   logic [12:0]     cfg_width;
   logic [15:0]     cfg_height;

   tlg5_pkg::rsp_type pixel_queue [$];
   plan_row_type      plan [PLAN_LEN];
   int                mismatches;
   int                pixels_checked;
   int                burst_left;
   int unsigned       cycle_count;

   tlg5_pixel_reconstruct #(.MAX_WIDTH(MAX_W)) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog
   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      mismatches++;
      $display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
   endtask

   // reconstruct one pixel and advance the row/column position
   function automatic tlg5_pkg::rsp_type reconstruct_pixel(input tlg5_pkg::req_type px);
      int unsigned       w;
      int unsigned       h;
      logic [3:0][7:0]   delta;
      logic [3:0][7:0]   above;
      logic [3:0][7:0]   lane_out;
      tlg5_pkg::rsp_type r;
      w = (cfg_width == 0) ? 1 : cfg_width;
      if (w > MAX_W) w = MAX_W;
      h = (cfg_height == 0) ? 1 : cfg_height;
      if (pixel_col == 0) row_sum = '0;
      // undo color decorrelation
      delta[0] = px.blue_delta + px.green_delta;
      delta[1] = px.green_delta;
      delta[2] = px.red_delta + px.green_delta;
      delta[3] = px.alpha_delta;
      above = (pixel_row != 0) ? line_mem[pixel_col] : '0;
      for (int c = 0; c < 4; c++) begin
         if (c < 3 || cfg_alpha) begin
            row_sum[c]  = row_sum[c] + delta[c];
            lane_out[c] = row_sum[c] + above[c];
         end else begin
            lane_out[c] = tlg5_pkg::OPAQUE;
         end
      end
      line_mem[pixel_col] = lane_out;
      if (pixel_col + 1 > filled_len) filled_len = pixel_col + 1;
      r.blue_out  = lane_out[0];
      r.green_out = lane_out[1];
      r.red_out   = lane_out[2];
      r.alpha_out = lane_out[3];
      // a counter at or past the last position ends the row (or frame)
      r.row_end   = (pixel_col >= w - 1);
      r.frame_end = r.row_end && (pixel_row >= h - 1);
      if (r.row_end) begin
         pixel_col = 0;
         pixel_row = r.frame_end ? 16'd0 : pixel_row + 16'd1;
      end else begin
         pixel_col++;
      end
      return r;
   endfunction

   function automatic plan_row_type csr_row(input logic [1:0] sel, input logic [15:0] val);
      plan_row_type row;
      row         = '0;
      row.is_csr  = 1'b1;
      row.csr_sel = sel;
      row.csr_val = val;
      return row;
   endfunction

   function automatic plan_row_type pix_row(input tlg5_pkg::req_type px, input logic known,
                                            input tlg5_pkg::rsp_type want);
      plan_row_type row;
      row       = '0;
      row.px    = px;
      row.known = known;
      row.want  = want;
      return row;
   endfunction

   function automatic tlg5_pkg::req_type random_pixel();
      logic [3:0][7:0] lanes;
      for (int c = 0; c < 4; c++) begin
         case ($urandom_range(0, 7))
            0:       lanes[c] = 8'h00;
            1:       lanes[c] = 8'hFF;
            default: lanes[c] = 8'($urandom);
         endcase
      end
      return tlg5_pkg::req_type'(lanes);
   endfunction

   // one request transfer; called and returns at a falling edge
   task automatic push_pixel(input tlg5_pkg::req_type px, input logic known,
                             input tlg5_pkg::rsp_type want);
      tlg5_pkg::rsp_type predicted;
      req_valid <= 1'b1;
      req_data  <= px;
      do @(posedge clock); while (!req_ready);
      predicted = reconstruct_pixel(px);
      pixel_queue.insert(pixel_queue.size(), known ? want : predicted);
      @(negedge clock);
   endtask

   // sender bursts with random gaps, some of them empty
   task automatic pace_sender();
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
   endtask

   // register write once the pipeline has drained
   task automatic write_csr(input logic [1:0] sel, input logic [15:0] val);
      req_valid <= 1'b0;
      while (pixel_queue.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= sel;
      csr_wdata <= val;
      case (sel)
         tlg5_pkg::CSR_HAS_ALPHA:    cfg_alpha  = val[0];
         tlg5_pkg::CSR_LINE_WIDTH:   cfg_width  = val[12:0];
         tlg5_pkg::CSR_FRAME_HEIGHT: cfg_height = val;
         default: ;
      endcase
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // response checker
   always @(posedge clock) begin : check_rsp
      tlg5_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pixel_queue.size() == 0) begin
            report_mismatch("response with no pixel pending", int'(rsp_data), 0);
         end else begin
            want = pixel_queue.pop_front();
            pixels_checked++;
            if (rsp_data.blue_out !== want.blue_out)
               report_mismatch("blue_out", int'(rsp_data.blue_out), int'(want.blue_out));
            if (rsp_data.green_out !== want.green_out)
               report_mismatch("green_out", int'(rsp_data.green_out), int'(want.green_out));
            if (rsp_data.red_out !== want.red_out)
               report_mismatch("red_out", int'(rsp_data.red_out), int'(want.red_out));
            if (rsp_data.alpha_out !== want.alpha_out)
               report_mismatch("alpha_out", int'(rsp_data.alpha_out), int'(want.alpha_out));
            if (rsp_data.row_end !== want.row_end)
               report_mismatch("row_end", int'(rsp_data.row_end), int'(want.row_end));
            if (rsp_data.frame_end !== want.frame_end)
               report_mismatch("frame_end", int'(rsp_data.frame_end), int'(want.frame_end));
         end
      end
   end

   // receiver: stall pattern drawn at random from four modes, plus one long hold-off
   // taken while the sender is offering, so the block fills and stalls
   initial begin : rsp_side
      int  mode;
      int  tick;
      bit  hold_done;
      rsp_ready = 1'b0;
      mode      = 0;
      tick      = 0;
      hold_done = 1'b0;
      forever begin
         @(negedge clock);
         if (!hold_done && pixels_checked >= 200 && req_valid) begin
            hold_done = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else begin
            if (tick % 64 == 0) mode = $urandom_range(0, 3);
            tick++;
            case (mode)
               0:       rsp_ready <= 1'b1;
               1:       rsp_ready <= 1'($urandom_range(0, 1));
               2:       rsp_ready <= ($urandom_range(0, 3) == 0);
               default: rsp_ready <= tick[0];
            endcase
         end
      end
   end

   // stimulus
   initial begin : stimulus
      int unsigned w_val;
      int unsigned h_val;
      int unsigned w_eff;
      int          n_items;
      int          sent_small;
      bit          big_done;
      bit          big_phase;

      req_valid  = 1'b0;
      req_data   = '0;
      csr_wr_en  = 1'b0;
      csr_index  = tlg5_pkg::CSR_HAS_ALPHA;
      csr_wdata  = '0;
      reset      = 1'b1;
      mismatches = 0;
      pixels_checked = 0;
      burst_left = 0;
      row_sum    = '0;
      pixel_col  = 0;
      pixel_row  = '0;
      filled_len = 0;
      cfg_alpha  = tlg5_pkg::HAS_ALPHA_RST;
      cfg_width  = tlg5_pkg::LINE_WIDTH_RST;
      cfg_height = tlg5_pkg::FRAME_HEIGHT_RST;
      sent_small = 0;
      big_done   = 1'b0;

      // directed plan, starting from reset registers (4 channels, 4096 x 1)
      plan[0]  = pix_row(32'h00000000, 1'b1, 34'h0_00000000);
      plan[1]  = pix_row(32'hFFFFFFFF, 1'b1, 34'h0_FFFEFFFE);
      plan[2]  = pix_row(32'h807F8001, 1'b0, '0);
      plan[3]  = csr_row(tlg5_pkg::CSR_LINE_WIDTH, 16'd2);     // column now past the end
      plan[4]  = pix_row(32'h78563412, 1'b0, '0);
      plan[5]  = csr_row(tlg5_pkg::CSR_FRAME_HEIGHT, 16'd0);   // zero height acts as one
      plan[6]  = pix_row(32'h03020100, 1'b0, '0);
      plan[7]  = pix_row(32'hA5C35A3C, 1'b0, '0);
      plan[8]  = csr_row(tlg5_pkg::CSR_LINE_WIDTH, 16'd0);     // zero width acts as one
      plan[9]  = csr_row(tlg5_pkg::CSR_FRAME_HEIGHT, 16'd3);
      plan[10] = pix_row(32'h11223344, 1'b0, '0);
      plan[11] = pix_row(32'hFF00FF00, 1'b0, '0);
      plan[12] = pix_row(32'h00FF00FF, 1'b0, '0);
      plan[13] = csr_row(tlg5_pkg::CSR_HAS_ALPHA, 16'd0);      // three-channel mode
      plan[14] = csr_row(tlg5_pkg::CSR_FRAME_HEIGHT, 16'd1);
      plan[15] = pix_row(32'h40302010, 1'b1, 34'h3_FF502030);
      plan[16] = csr_row(tlg5_pkg::CSR_LINE_WIDTH, 16'd8191);  // saturates to the buffer size
      plan[17] = pix_row(32'h00FE01FF, 1'b0, '0);
      plan[18] = pix_row(32'h80808080, 1'b0, '0);
      plan[19] = csr_row(tlg5_pkg::CSR_HAS_ALPHA, 16'd1);
      plan[20] = csr_row(tlg5_pkg::CSR_LINE_WIDTH, 16'd3);
      plan[21] = csr_row(tlg5_pkg::CSR_FRAME_HEIGHT, 16'd65535);
      plan[22] = pix_row(32'h5A5A5A5A, 1'b0, '0);
      plan[23] = pix_row(32'h01010101, 1'b0, '0);
      plan[24] = pix_row(32'h7F7F7F7F, 1'b0, '0);
      plan[25] = pix_row(32'hFFFFFFFF, 1'b0, '0);

      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (plan[i]) begin
         if (plan[i].is_csr) begin
            write_csr(plan[i].csr_sel, plan[i].csr_val);
         end else begin
            pace_sender();
            push_pixel(plan[i].px, plan[i].known, plan[i].want);
         end
      end

      // random phases; one phase runs two full rows of a wider image
      while (sent_small < 1100 || !big_done) begin
         big_phase = !big_done && sent_small >= 300 && pixel_row == 0;
         if (big_phase) begin
            w_val   = $urandom_range(100, 200);
            h_val   = 2;
            n_items = 2 * w_val + $urandom_range(0, 20);
            big_done = 1'b1;
         end else begin
            case ($urandom_range(0, 9))
               0:       w_val = 0;
               1:       w_val = 1;
               2:       w_val = $urandom_range(4097, 8191);
               default: w_val = $urandom_range(2, 12);
            endcase
            case ($urandom_range(0, 9))
               0:       h_val = 0;
               1:       h_val = 65535;
               default: h_val = $urandom_range(1, 6);
            endcase
            n_items = $urandom_range(10, 80);
         end
         // past the first row, never widen beyond the columns already stored
         w_eff = (w_val == 0) ? 1 : ((w_val > MAX_W) ? MAX_W : w_val);
         if (pixel_row != 0 && w_eff > filled_len) w_val = filled_len;

         write_csr(tlg5_pkg::CSR_HAS_ALPHA, 16'($urandom_range(0, 1)));
         write_csr(tlg5_pkg::CSR_LINE_WIDTH, 16'(w_val));
         write_csr(tlg5_pkg::CSR_FRAME_HEIGHT, 16'(h_val));
         for (int k = 0; k < n_items; k++) begin
            pace_sender();
            push_pixel(random_pixel(), 1'b0, '0);
         end
         sent_small += n_items;
      end

      // drain, then allow for the pipeline latency
      req_valid <= 1'b0;
      while (pixel_queue.size() != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      if (mismatches == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

// ===== sim.f =====
design/tlg5_pkg.sv
design/tlg5_ram.sv
design/tlg5_pos.sv
design/tlg5_lane.sv
design/tlg5_pixel_reconstruct.sv
bench/tlg5_pixel_reconstruct_tb.sv
